// File: src/mmss_pkg.sv
// Package for the seven-segment clock/voltmeter scanner.
// Widths, limits, reciprocal constants and the segment/select tables.
// No dependencies.
package mmss_pkg;

  localparam int ADC_BITS      = 12;
  localparam int ADC_TOP       = (1 << ADC_BITS) - 1;
  localparam int FS_BITS       = 14;
  localparam logic [FS_BITS-1:0] FS_RESET = 14'd3300;

  localparam int MV_BITS       = 14;
  localparam int MV_SAT        = 9999;

  localparam int SECONDS_LIMIT = 6000;
  localparam int SEC_BITS      = $clog2(SECONDS_LIMIT);
  localparam int MIN_BITS      = 7;
  // minutes = (secs * MIN_RECIP) >> MIN_SHIFT, exact below 8192
  localparam int MIN_RECIP     = 17477;
  localparam int MIN_RECIP_BITS = 15;
  localparam int MIN_SHIFT     = 20;

  // x / D = (x * R) >> RECIP_SHIFT, exact for x below 16384
  localparam int RECIP_SHIFT   = 24;
  localparam int RECIP_BITS    = RECIP_SHIFT + 1;
  localparam logic [RECIP_BITS-1:0] RECIP_1000 = 25'd16778;
  localparam logic [RECIP_BITS-1:0] RECIP_100  = 25'd167773;
  localparam logic [RECIP_BITS-1:0] RECIP_10   = 25'd1677722;
  localparam logic [RECIP_BITS-1:0] RECIP_1    = 25'd16777216;

  // x % 10 via x / 10 = (x * 52429) >> 19, exact for 16-bit x
  localparam int DIV10_BITS    = 16;
  localparam logic [DIV10_BITS-1:0] DIV10_MUL = 16'd52429;
  localparam int DIV10_SHIFT   = 19;

  localparam int WORD_BITS     = 16;
  localparam int CNT_BITS      = $clog2(WORD_BITS);
  localparam int DIGITS        = 4;
  localparam int IDX_BITS      = $clog2(DIGITS);

  localparam logic REQ_SECOND  = 1'b0;
  localparam logic REQ_REFRESH = 1'b1;
  localparam logic MODE_VOLTS  = 1'b0;

  localparam logic [7:0] POINT_MASK = 8'h7F;

  localparam logic [7:0] SEG_CODE [10] = '{
    8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
  };

  localparam logic [7:0] SEL_CODE [DIGITS] = '{8'hF1, 8'hF2, 8'hF4, 8'hF8};

endpackage

// File: src/mmss_if.sv
// Valid/ready channel interfaces for the scanner: tick items in, serial bits out.
// Depends on mmss_pkg.
interface mmss_in_if
  import mmss_pkg::*;
();
  logic                valid;
  logic                ready;
  logic                req_type;
  logic                reset_button;
  logic                mode_button;
  logic [ADC_BITS-1:0] adc_sample;

  modport source (output valid, req_type, reset_button, mode_button, adc_sample,
                  input ready);
  modport sink   (input valid, req_type, reset_button, mode_button, adc_sample,
                  output ready);
endinterface

interface mmss_out_if;
  logic valid;
  logic ready;
  logic serial_bit;
  logic last_bit;

  modport source (output valid, serial_bit, last_bit, input ready);
  modport sink   (input valid, serial_bit, last_bit, output ready);
endinterface

// File: src/mmss_mv_div.sv
// Scales product adc*full_scale down by the converter full-scale code, saturating.
// Combinational; depends on mmss_pkg.
module mmss_mv_div
  import mmss_pkg::*;
(
  input  logic [ADC_BITS+FS_BITS-1:0] prod,
  output logic [MV_BITS-1:0]          mv
);

  localparam int P_BITS  = ADC_BITS + FS_BITS;
  localparam int Q_BITS  = P_BITS - ADC_BITS + 1;
  localparam int DIV_FIX = 2;

  logic [P_BITS:0]   sum;
  logic [Q_BITS-1:0] q_est;
  logic [Q_BITS-1:0] q_fix;
  logic [P_BITS:0]   rem;

  // 1/(2^n-1) = 2^-n (1 + 2^-n + 2^-2n ...); estimate never overshoots
  assign sum   = {1'b0, prod} + (P_BITS+1)'(prod >> ADC_BITS)
               + (P_BITS+1)'(prod >> (2 * ADC_BITS));
  assign q_est = sum[P_BITS:ADC_BITS];

  always_comb begin
    q_fix = q_est;
    rem   = {1'b0, prod} - ((P_BITS+1)'(q_est) << ADC_BITS) + (P_BITS+1)'(q_est);
    for (int i = 0; i < DIV_FIX; i++) begin
      if (rem >= (P_BITS+1)'(ADC_TOP)) begin
        rem   = rem - (P_BITS+1)'(ADC_TOP);
        q_fix = q_fix + 1'b1;
      end
    end
    mv = (q_fix > Q_BITS'(MV_SAT)) ? MV_BITS'(MV_SAT) : q_fix[MV_BITS-1:0];
  end

endmodule

// File: src/mmss_serialiser.sv
// Output shift register: loads one 16-bit word, sends it MSB first, one bit per beat.
// Depends on mmss_pkg and mmss_out_if.
module mmss_serialiser
  import mmss_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load_valid,
  output logic                 load_ready,
  input  logic [WORD_BITS-1:0] load_word,
  mmss_out_if.source           bits
);

  logic                 busy;
  logic [CNT_BITS-1:0]  cnt;
  logic [WORD_BITS-1:0] shreg;
  logic                 at_last;

  assign at_last    = (cnt == CNT_BITS'(WORD_BITS - 1));
  assign load_ready = !busy || (bits.ready && at_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (load_valid && load_ready) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy && bits.ready) begin
      if (at_last) begin
        busy <= 1'b0;
      end
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_valid && load_ready) begin
      shreg <= load_word;
    end else if (busy && bits.ready) begin
      shreg <= {shreg[WORD_BITS-2:0], 1'b0};
    end
  end

  assign bits.valid      = busy;
  assign bits.serial_bit = shreg[WORD_BITS-1];
  assign bits.last_bit   = at_last;

endmodule

// File: src/mmss_clock_seven_segment_scanner_unit.sv
// Top level of the four-digit seven-segment clock/voltmeter scanner.
// Depends on mmss_pkg, mmss_if, mmss_mv_div and mmss_serialiser.

// One-second ticks are taken and give no output beats. A refresh tick passes a four-stage
// pipeline (scale, divide, digit select, segment encode) and then leaves as 16 serial beats,
// segment byte then select byte, MSB first, with last_bit on the sixteenth. The first beat
// is offered once the word has been loaded from stage 4 into the output shift register.
// The output shift register sends one bit per beat; up to four more refresh ticks are
// taken while a word shifts. Ticks of either kind are taken only while the first stage
// can move, so four refresh ticks held behind a stalled output hold off all input.
// full_scale resets to 3300 and is written by cfg_we/cfg_wdata.
module mmss_clock_seven_segment_scanner_unit
  import mmss_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [FS_BITS-1:0] cfg_wdata,
  mmss_in_if.sink            item,
  mmss_out_if.source         bits
);

  localparam int P_BITS = ADC_BITS + FS_BITS;

  logic [FS_BITS-1:0]  full_scale;
  logic [SEC_BITS-1:0] seconds_count;
  logic [SEC_BITS-1:0] seconds_next;
  logic [IDX_BITS-1:0] digit_index;
  logic                previous_reset_level;

  logic                accept;
  logic [SEC_BITS-1:0] secs_base;
  logic [SEC_BITS:0]   secs_inc;

  // pipeline occupancy and advance
  logic v1, v2, v3, v4;
  logic adv1, adv2, adv3, adv4;
  logic load_ready;

  // stage 1
  logic                s1_mode;
  logic [IDX_BITS-1:0] s1_idx;
  logic [ADC_BITS-1:0] s1_adc;
  logic [SEC_BITS-1:0] s1_secs;
  logic [P_BITS-1:0]   s1_prod;
  logic [SEC_BITS+MIN_RECIP_BITS-1:0] s1_min_prod;

  // stage 2
  logic                s2_mode;
  logic [IDX_BITS-1:0] s2_idx;
  logic [P_BITS-1:0]   s2_prod;
  logic [SEC_BITS-1:0] s2_secs;
  logic [MIN_BITS-1:0] s2_mins;
  logic [MV_BITS-1:0]  s2_mv;
  logic [SEC_BITS-1:0] s2_srem;

  // stage 3
  logic                s3_mode;
  logic [IDX_BITS-1:0] s3_idx;
  logic [MV_BITS-1:0]  s3_mv;
  logic [MIN_BITS-1:0] s3_mins;
  logic [5:0]          s3_srem;
  logic [MV_BITS-1:0]  s3_x;
  logic [RECIP_BITS-1:0] s3_recip;
  logic [MV_BITS+RECIP_BITS-1:0] s3_qprod;

  // stage 4
  logic                s4_mode;
  logic [IDX_BITS-1:0] s4_idx;
  logic [MV_BITS-1:0]  s4_q;
  logic [MV_BITS+DIV10_BITS-1:0] s4_tprod;
  logic [MV_BITS-1:0]  s4_tens;
  logic [MV_BITS-1:0]  s4_rem;
  logic [7:0]          s4_seg;
  logic                s4_point;
  logic [WORD_BITS-1:0] s4_word;

  // ---- input side and block state ----
  assign adv4 = v4 && load_ready;
  assign adv3 = v3 && (!v4 || adv4);
  assign adv2 = v2 && (!v3 || adv3);
  assign adv1 = v1 && (!v2 || adv2);

  assign item.ready = !v1 || adv1;
  assign accept     = item.valid && item.ready;

  // falling edge of the reset button clears time before the tick is applied
  assign secs_base = (!item.reset_button && previous_reset_level) ? '0 : seconds_count;
  assign secs_inc  = {1'b0, secs_base} + 1'b1;

  always_comb begin
    seconds_next = secs_base;
    if (item.req_type == REQ_SECOND) begin
      seconds_next = (secs_inc >= (SEC_BITS+1)'(SECONDS_LIMIT)) ? '0
                                                                : secs_inc[SEC_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full_scale <= FS_RESET;
    end else if (cfg_we) begin
      full_scale <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seconds_count        <= '0;
      digit_index          <= '0;
      previous_reset_level <= 1'b1;
    end else if (accept) begin
      seconds_count        <= seconds_next;
      previous_reset_level <= item.reset_button;
      if (item.req_type == REQ_REFRESH) begin
        digit_index <= digit_index + 1'b1;
      end
    end
  end

  // ---- pipeline valid flags ----
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (!v1 || adv1) v1 <= accept && (item.req_type == REQ_REFRESH);
      if (!v2 || adv2) v2 <= adv1;
      if (!v3 || adv3) v3 <= adv2;
      if (!v4 || adv4) v4 <= adv3;
    end
  end

  // ---- stage 1: scale product and minutes ----
  always_ff @(posedge clk) begin
    if (!v1 || adv1) begin
      s1_mode <= item.mode_button;
      s1_idx  <= digit_index;
      s1_adc  <= item.adc_sample;
      s1_secs <= secs_base;
    end
  end

  assign s1_prod     = P_BITS'(s1_adc) * P_BITS'(full_scale);
  assign s1_min_prod = (SEC_BITS+MIN_RECIP_BITS)'(s1_secs)
                     * (SEC_BITS+MIN_RECIP_BITS)'(MIN_RECIP);

  // ---- stage 2: millivolts and seconds remainder ----
  always_ff @(posedge clk) begin
    if (!v2 || adv2) begin
      s2_mode <= s1_mode;
      s2_idx  <= s1_idx;
      s2_prod <= s1_prod;
      s2_secs <= s1_secs;
      s2_mins <= s1_min_prod[MIN_SHIFT +: MIN_BITS];
    end
  end

  mmss_mv_div u_mv_div (
    .prod (s2_prod),
    .mv   (s2_mv)
  );

  assign s2_srem = s2_secs - ((SEC_BITS'(s2_mins) << 6) - (SEC_BITS'(s2_mins) << 2));

  // ---- stage 3: pick the value and divide down to the wanted digit ----
  always_ff @(posedge clk) begin
    if (!v3 || adv3) begin
      s3_mode <= s2_mode;
      s3_idx  <= s2_idx;
      s3_mv   <= s2_mv;
      s3_mins <= s2_mins;
      s3_srem <= s2_srem[5:0];
    end
  end

  always_comb begin
    if (s3_mode == MODE_VOLTS) begin
      s3_x = s3_mv;
      case (s3_idx)
        2'd0:    s3_recip = RECIP_1000;
        2'd1:    s3_recip = RECIP_100;
        2'd2:    s3_recip = RECIP_10;
        default: s3_recip = RECIP_1;
      endcase
    end else begin
      s3_x     = (s3_idx < 2'd2) ? MV_BITS'(s3_mins) : MV_BITS'(s3_srem);
      s3_recip = s3_idx[0] ? RECIP_1 : RECIP_10;
    end
  end

  assign s3_qprod = (MV_BITS+RECIP_BITS)'(s3_x) * (MV_BITS+RECIP_BITS)'(s3_recip);

  // ---- stage 4: modulo ten, segment encode, word assembly ----
  always_ff @(posedge clk) begin
    if (!v4 || adv4) begin
      s4_mode <= s3_mode;
      s4_idx  <= s3_idx;
      s4_q    <= s3_qprod[RECIP_SHIFT +: MV_BITS];
    end
  end

  assign s4_tprod = (MV_BITS+DIV10_BITS)'(s4_q) * (MV_BITS+DIV10_BITS)'(DIV10_MUL);
  assign s4_tens  = MV_BITS'(s4_tprod >> DIV10_SHIFT);
  assign s4_rem   = s4_q - (s4_tens << 3) - (s4_tens << 1);

  // colon on digit 1 for time, decimal point on digit 0 for volts
  assign s4_point = (s4_mode == MODE_VOLTS) ? (s4_idx == 2'd0) : (s4_idx == 2'd1);
  assign s4_seg   = s4_point ? (SEG_CODE[s4_rem[3:0]] & POINT_MASK) : SEG_CODE[s4_rem[3:0]];
  assign s4_word  = {s4_seg, SEL_CODE[s4_idx]};

  mmss_serialiser u_serialiser (
    .clk        (clk),
    .rst        (rst),
    .load_valid (v4),
    .load_ready (load_ready),
    .load_word  (s4_word),
    .bits       (bits)
  );

endmodule

// File: src/mmss_checker.sv
// Port-level checks for the scanner top level, attached by bind.
// Depends on the top level's ports only.
module mmss_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_serial_bit,
  input logic out_last_bit
);

  // a word is never cut short: a non-final beat is always followed by another
  a_word_continues: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_last_bit |=> out_valid)
    else $error("serial word ended before its last beat");

  // beat counter must restart after the last beat of a word
  a_last_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_last_bit |=> !(out_valid && out_last_bit))
    else $error("last beat repeated");

  a_reset_out_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output beat offered straight after reset");

  a_reset_in_ready: assert property (@(posedge clk) rst |=> in_ready)
    else $error("input not ready straight after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_serial_bit)
                                && $stable(out_last_bit))
    else $error("stalled output beat changed");

endmodule

bind mmss_clock_seven_segment_scanner_unit mmss_checker u_mmss_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (item.valid),
  .in_ready       (item.ready),
  .out_valid      (bits.valid),
  .out_ready      (bits.ready),
  .out_serial_bit (bits.serial_bit),
  .out_last_bit   (bits.last_bit)
);
